// ===== rtl/hptd_pkg.sv =====
// Package: shared types and constants for the preorder-tree Huffman decoder.
package hptd_pkg;

    // Width of the symbol count register
    localparam int CFG_W = 40;
    // Tree description characters
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;

    // Input beat
    typedef struct packed {
        logic       cmd;
        logic [7:0] stream_byte;
    } in_item_t;

    // Output beat
    typedef struct packed {
        logic [7:0] symbol;
        logic       last_of_run;
        logic       stream_done;
        logic       error;
    } out_item_t;

    // Input command codes
    typedef enum logic {
        CMD_BYTE  = 1'b0,
        CMD_START = 1'b1
    } cmd_t;

    // Stream phase
    typedef enum logic [1:0] {
        PH_PARSE  = 2'd0,
        PH_DECODE = 2'd1,
        PH_DONE   = 2'd2,
        PH_ERROR  = 2'd3
    } phase_t;

    // Sequencer state
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_PARSE  = 3'd1,
        ST_POP    = 3'd2,
        ST_DSTART = 3'd3,
        ST_DSTEP  = 3'd4,
        ST_FLUSH  = 3'd5
    } state_t;

    // Per-node leaf flag and symbol
    typedef struct packed {
        logic       leaf;
        logic [7:0] sym;
    } node_attr_t;

    // Node memory write enables
    typedef struct packed {
        logic attr;
        logic left;
        logic right;
    } node_wen_t;

endpackage

// ===== rtl/hptd_node_mem.sv =====
// Node memory: leaf/symbol, left child and right child arrays with one shared read port.
module hptd_node_mem #(
    parameter int NODE_DEPTH = 512
) (
    input  logic                          clk,
    input  hptd_pkg::node_wen_t           wen,
    input  logic [$clog2(NODE_DEPTH)-1:0] attr_waddr,
    input  hptd_pkg::node_attr_t          attr_wdata,
    input  logic [$clog2(NODE_DEPTH)-1:0] child_waddr,
    input  logic [$clog2(NODE_DEPTH)-1:0] child_wdata,
    input  logic                          rd_en,
    input  logic [$clog2(NODE_DEPTH)-1:0] raddr,
    output hptd_pkg::node_attr_t          rd_attr,
    output logic [$clog2(NODE_DEPTH)-1:0] rd_left,
    output logic [$clog2(NODE_DEPTH)-1:0] rd_right
);

    localparam int IW = $clog2(NODE_DEPTH);

    hptd_pkg::node_attr_t attr_mem  [NODE_DEPTH];
    logic [IW-1:0]        left_mem  [NODE_DEPTH];
    logic [IW-1:0]        right_mem [NODE_DEPTH];

    hptd_pkg::node_attr_t rd_attr_reg;
    logic [IW-1:0]        rd_left_reg;
    logic [IW-1:0]        rd_right_reg;

    // Write ports, one per array
    always_ff @(posedge clk)
    begin
        if (wen.attr)
        begin
            attr_mem[attr_waddr] <= attr_wdata;
        end
        if (wen.left)
        begin
            left_mem[child_waddr] <= child_wdata;
        end
        if (wen.right)
        begin
            right_mem[child_waddr] <= child_wdata;
        end
    end

    // Registered read of one whole node; data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_attr_reg  <= attr_mem[raddr];
            rd_left_reg  <= left_mem[raddr];
            rd_right_reg <= right_mem[raddr];
        end
    end

    assign rd_attr  = rd_attr_reg;
    assign rd_left  = rd_left_reg;
    assign rd_right = rd_right_reg;

endmodule

// ===== rtl/huffman_preorder_tree_decoder_top.sv =====
// Top level: preorder-tree Huffman decoder, tree parser and bit-serial tree walker.
//
// One stream byte per input beat. While the tree is being parsed a byte is accepted and
// then makes one node/stack update; when a leaf closes a subtree the new stack top is
// also reloaded from the stack memory. While decoding, a byte is accepted, the first
// child is fetched, each code bit takes one read of the node memory (the walker's only
// port) and the last symbol goes out with last_of_run set; the walk stops early when
// the symbol count is reached inside the byte and waits when the output side stalls.
// Bytes in the done or error phase and start commands are only accepted. A finished
// result waits in an output register, so the next byte is accepted while it is pending.
module huffman_preorder_tree_decoder_top #(
    parameter int NODE_DEPTH  = 512,
    parameter int STACK_DEPTH = 256,
    parameter int COUNT_BITS  = 40
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  hptd_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output hptd_pkg::out_item_t               out_data,
    input  logic                              cfg_we,
    input  logic [hptd_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int IW  = $clog2(NODE_DEPTH);
    localparam int NUW = $clog2(NODE_DEPTH + 1);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int LW  = $clog2(STACK_DEPTH + 1);

    // Control state
    hptd_pkg::state_t     state_reg, state_next;
    hptd_pkg::phase_t     phase_reg, phase_next;
    logic [NUW-1:0]       nodes_used_reg, nodes_used_next;
    logic [LW-1:0]        stack_level_reg, stack_level_next;
    logic                 top_rn_reg, top_rn_next;
    logic                 awaiting_reg, awaiting_next;
    logic                 root_leaf_reg, root_leaf_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 out_valid_reg, out_valid_next;
    logic [hptd_pkg::CFG_W-1:0] count_reg, count_next;

    // Payload state
    logic [7:0]           byte_reg, byte_next;
    logic [2:0]           bitpos_reg, bitpos_next;
    logic [IW-1:0]        top_idx_reg, top_idx_next;
    logic [IW-1:0]        root_l_reg, root_l_next;
    logic [IW-1:0]        root_r_reg, root_r_next;
    logic [IW-1:0]        wl_reg, wl_next;
    logic [IW-1:0]        wr_reg, wr_next;
    logic [7:0]           pend_sym_reg, pend_sym_next;
    logic                 pend_done_reg, pend_done_next;
    hptd_pkg::out_item_t  out_reg, out_next;

    // Node memory interface
    hptd_pkg::node_wen_t  node_wen;
    logic [IW-1:0]        attr_waddr;
    hptd_pkg::node_attr_t attr_wdata;
    logic [IW-1:0]        child_waddr;
    logic [IW-1:0]        child_wdata;
    logic                 node_rd_en;
    logic [IW-1:0]        node_raddr;
    hptd_pkg::node_attr_t rd_attr;
    logic [IW-1:0]        rd_left;
    logic [IW-1:0]        rd_right;

    // Stack memory: entries below the top, {node index, right-next}
    logic [IW:0]          stk_mem [STACK_DEPTH];
    logic                 stk_we;
    logic [SW-1:0]        stk_waddr;
    logic [IW:0]          stk_wdata;
    logic                 stk_re;
    logic [SW-1:0]        stk_raddr;
    logic [IW:0]          stk_rdata_reg;

    // Shared decisions
    logic                 in_acc;
    logic                 out_free;
    logic                 out_push;
    hptd_pkg::out_item_t  out_push_data;
    logic [COUNT_BITS-1:0] target;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                 count_met;
    logic                 inc_met;
    logic [IW-1:0]        idx;
    logic                 popped;
    logic [LW-1:0]        lvl_after;
    logic [LW-1:0]        lvl_after_m1;
    logic [NUW-1:0]       nu_m1;
    logic                 parse_pop;
    logic                 dstep_stall;
    logic                 dstep_stop;
    logic                 flush_go;

    assign in_ready  = (state_reg == hptd_pkg::ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Target count, saturated to the counter width
    generate
        if (COUNT_BITS < hptd_pkg::CFG_W)
        begin : g_sat
            assign target = (|count_reg[hptd_pkg::CFG_W-1:COUNT_BITS]) ? '1
                                                                         : count_reg[COUNT_BITS-1:0];
        end
        else
        begin : g_ext
            assign target = COUNT_BITS'(count_reg);
        end
    endgenerate

    // Counter compares
    assign cnt_inc   = cnt_reg + 1'b1;
    assign count_met = (cnt_reg >= target);
    assign inc_met   = (cnt_inc >= target);

    // Parse helpers: new node index and stack level after closing the top
    assign idx          = nodes_used_reg[IW-1:0];
    assign popped       = (stack_level_reg != '0) && top_rn_reg;
    assign lvl_after    = popped ? (stack_level_reg - 1'b1) : stack_level_reg;
    assign lvl_after_m1 = lvl_after - 1'b1;
    assign nu_m1        = nodes_used_reg - 1'b1;

    // Datapath and outputs
    always_comb
    begin
        phase_next       = phase_reg;
        nodes_used_next  = nodes_used_reg;
        stack_level_next = stack_level_reg;
        top_rn_next      = top_rn_reg;
        awaiting_next    = awaiting_reg;
        root_leaf_next   = root_leaf_reg;
        cnt_next         = cnt_reg;
        pend_valid_next  = pend_valid_reg;
        count_next       = count_reg;
        byte_next        = byte_reg;
        bitpos_next      = bitpos_reg;
        top_idx_next     = top_idx_reg;
        root_l_next      = root_l_reg;
        root_r_next      = root_r_reg;
        wl_next          = wl_reg;
        wr_next          = wr_reg;
        pend_sym_next    = pend_sym_reg;
        pend_done_next   = pend_done_reg;

        node_wen         = '0;
        attr_waddr       = '0;
        attr_wdata       = '0;
        child_waddr      = top_idx_reg;
        child_wdata      = idx;
        node_rd_en       = 1'b0;
        node_raddr       = '0;
        stk_we           = 1'b0;
        stk_waddr        = lvl_after_m1[SW-1:0];
        stk_wdata        = {top_idx_reg, 1'b1};
        stk_re           = 1'b0;
        stk_raddr        = lvl_after_m1[SW-1:0];

        out_push         = 1'b0;
        out_push_data    = '0;
        parse_pop        = 1'b0;
        dstep_stall      = 1'b0;
        dstep_stop       = 1'b0;
        flush_go         = 1'b0;

        // Register write
        if (cfg_we)
        begin
            count_next = cfg_wdata;
        end

        case (state_reg)
            hptd_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    byte_next = in_data.stream_byte;
                    // Start of a new stream clears tree, stack and counters
                    if (in_data.cmd == hptd_pkg::CMD_START)
                    begin
                        phase_next       = hptd_pkg::PH_PARSE;
                        nodes_used_next  = '0;
                        stack_level_next = '0;
                        awaiting_next    = 1'b0;
                        root_leaf_next   = 1'b0;
                        cnt_next         = '0;
                        pend_valid_next  = 1'b0;
                    end
                end
            end

            hptd_pkg::ST_PARSE:
            begin
                if (out_free)
                begin
                    if (awaiting_reg)
                    begin
                        // Symbol byte of the last leaf
                        awaiting_next   = 1'b0;
                        node_wen.attr   = 1'b1;
                        attr_waddr      = nu_m1[IW-1:0];
                        attr_wdata.leaf = 1'b1;
                        attr_wdata.sym  = byte_reg;
                        if (stack_level_reg == '0)
                        begin
                            if (root_leaf_reg)
                            begin
                                phase_next = hptd_pkg::PH_ERROR;
                                out_push   = 1'b1;
                            end
                            else
                            begin
                                phase_next = count_met ? hptd_pkg::PH_DONE : hptd_pkg::PH_DECODE;
                                wl_next    = root_l_reg;
                                wr_next    = root_r_reg;
                            end
                        end
                    end
                    else if (nodes_used_reg >= NUW'(NODE_DEPTH))
                    begin
                        // Node overflow
                        phase_next = hptd_pkg::PH_ERROR;
                        out_push   = 1'b1;
                    end
                    else
                    begin
                        // Link the new node under the open node on top
                        if (stack_level_reg != '0)
                        begin
                            node_wen.left  = !top_rn_reg;
                            node_wen.right = top_rn_reg;
                            if (top_idx_reg == '0)
                            begin
                                if (!top_rn_reg)
                                begin
                                    root_l_next = idx;
                                end
                                else
                                begin
                                    root_r_next = idx;
                                end
                            end
                            top_rn_next = 1'b1;
                        end
                        attr_waddr = idx;
                        if (byte_reg == hptd_pkg::CHAR_ZERO)
                        begin
                            // Internal node: push
                            if (lvl_after >= LW'(STACK_DEPTH))
                            begin
                                phase_next = hptd_pkg::PH_ERROR;
                                out_push   = 1'b1;
                            end
                            else
                            begin
                                node_wen.attr    = 1'b1;
                                attr_wdata.leaf  = 1'b0;
                                stk_we           = (lvl_after != '0) && !popped;
                                top_idx_next     = idx;
                                top_rn_next      = 1'b0;
                                stack_level_next = lvl_after + 1'b1;
                                nodes_used_next  = nodes_used_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            // Leaf
                            node_wen.attr    = 1'b1;
                            attr_wdata.leaf  = 1'b1;
                            nodes_used_next  = nodes_used_reg + 1'b1;
                            stack_level_next = lvl_after;
                            if (idx == '0)
                            begin
                                root_leaf_next = 1'b1;
                            end
                            if (popped && (lvl_after != '0))
                            begin
                                stk_re    = 1'b1;
                                parse_pop = 1'b1;
                            end
                            if (byte_reg == hptd_pkg::CHAR_ONE)
                            begin
                                awaiting_next = 1'b1;
                            end
                            else if (lvl_after == '0)
                            begin
                                if (idx == '0)
                                begin
                                    phase_next = hptd_pkg::PH_ERROR;
                                    out_push   = 1'b1;
                                end
                                else
                                begin
                                    phase_next = count_met ? hptd_pkg::PH_DONE
                                                           : hptd_pkg::PH_DECODE;
                                    wl_next    = root_l_next;
                                    wr_next    = root_r_next;
                                end
                            end
                        end
                    end
                    // Error beat carries no symbol
                    out_push_data.last_of_run = 1'b1;
                    out_push_data.error       = 1'b1;
                end
            end

            hptd_pkg::ST_POP:
            begin
                // Reload the stack top
                top_idx_next = stk_rdata_reg[IW:1];
                top_rn_next  = stk_rdata_reg[0];
            end

            hptd_pkg::ST_DSTART:
            begin
                if (count_met)
                begin
                    phase_next = hptd_pkg::PH_DONE;
                end
                else
                begin
                    node_rd_en  = 1'b1;
                    node_raddr  = byte_reg[7] ? wr_reg : wl_reg;
                    bitpos_next = 3'd7;
                end
            end

            hptd_pkg::ST_DSTEP:
            begin
                // Read data is the child selected by the current bit
                dstep_stall = rd_attr.leaf && pend_valid_reg && !out_free;
                if (!dstep_stall)
                begin
                    if (rd_attr.leaf)
                    begin
                        out_push                  = pend_valid_reg;
                        out_push_data.symbol      = pend_sym_reg;
                        out_push_data.stream_done = pend_done_reg;
                        pend_valid_next           = 1'b1;
                        pend_sym_next             = rd_attr.sym;
                        pend_done_next            = inc_met;
                        cnt_next                  = cnt_inc;
                        wl_next                   = root_l_reg;
                        wr_next                   = root_r_reg;
                    end
                    else
                    begin
                        wl_next = rd_left;
                        wr_next = rd_right;
                    end
                    dstep_stop = (bitpos_reg == 3'd0) || (rd_attr.leaf && inc_met);
                    if (!dstep_stop)
                    begin
                        bitpos_next = bitpos_reg - 1'b1;
                        node_rd_en  = 1'b1;
                        node_raddr  = byte_reg[bitpos_next] ? wr_next : wl_next;
                    end
                end
            end

            hptd_pkg::ST_FLUSH:
            begin
                // Last symbol of this byte goes out with last_of_run
                flush_go = !pend_valid_reg || out_free;
                if (flush_go)
                begin
                    out_push                  = pend_valid_reg;
                    out_push_data.symbol      = pend_sym_reg;
                    out_push_data.last_of_run = 1'b1;
                    out_push_data.stream_done = pend_done_reg;
                    pend_valid_next           = 1'b0;
                    if (count_met)
                    begin
                        phase_next = hptd_pkg::PH_DONE;
                    end
                end
            end

            default:
            begin
            end
        endcase

        // Output register
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        if (out_push)
        begin
            out_valid_next = 1'b1;
            out_next       = out_push_data;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hptd_pkg::ST_IDLE:
            begin
                if (in_acc && (in_data.cmd == hptd_pkg::CMD_BYTE))
                begin
                    case (phase_reg)
                        hptd_pkg::PH_PARSE:  state_next = hptd_pkg::ST_PARSE;
                        hptd_pkg::PH_DECODE: state_next = hptd_pkg::ST_DSTART;
                        default:             state_next = hptd_pkg::ST_IDLE;
                    endcase
                end
            end
            hptd_pkg::ST_PARSE:
            begin
                if (out_free)
                begin
                    state_next = parse_pop ? hptd_pkg::ST_POP : hptd_pkg::ST_IDLE;
                end
            end
            hptd_pkg::ST_POP:
            begin
                state_next = hptd_pkg::ST_IDLE;
            end
            hptd_pkg::ST_DSTART:
            begin
                state_next = count_met ? hptd_pkg::ST_IDLE : hptd_pkg::ST_DSTEP;
            end
            hptd_pkg::ST_DSTEP:
            begin
                if (!dstep_stall && dstep_stop)
                begin
                    state_next = hptd_pkg::ST_FLUSH;
                end
            end
            hptd_pkg::ST_FLUSH:
            begin
                if (flush_go)
                begin
                    state_next = hptd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hptd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= hptd_pkg::ST_IDLE;
            phase_reg       <= hptd_pkg::PH_PARSE;
            nodes_used_reg  <= '0;
            stack_level_reg <= '0;
            top_rn_reg      <= 1'b0;
            awaiting_reg    <= 1'b0;
            root_leaf_reg   <= 1'b0;
            cnt_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            count_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            nodes_used_reg  <= nodes_used_next;
            stack_level_reg <= stack_level_next;
            top_rn_reg      <= top_rn_next;
            awaiting_reg    <= awaiting_next;
            root_leaf_reg   <= root_leaf_next;
            cnt_reg         <= cnt_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
            count_reg       <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        bitpos_reg    <= bitpos_next;
        top_idx_reg   <= top_idx_next;
        root_l_reg    <= root_l_next;
        root_r_reg    <= root_r_next;
        wl_reg        <= wl_next;
        wr_reg        <= wr_next;
        pend_sym_reg  <= pend_sym_next;
        pend_done_reg <= pend_done_next;
        out_reg       <= out_next;
    end

    // Stack memory
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rdata_reg <= stk_mem[stk_raddr];
        end
    end

    // Node memory
    hptd_node_mem #(
        .NODE_DEPTH (NODE_DEPTH)
    ) u_node_mem (
        .clk         (clk),
        .wen         (node_wen),
        .attr_waddr  (attr_waddr),
        .attr_wdata  (attr_wdata),
        .child_waddr (child_waddr),
        .child_wdata (child_wdata),
        .rd_en       (node_rd_en),
        .raddr       (node_raddr),
        .rd_attr     (rd_attr),
        .rd_left     (rd_left),
        .rd_right    (rd_right)
    );

    // A new beat is only loaded when the output register frees up
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (!out_valid_reg || out_ready))
        else $error("output beat overwritten");

    // Tree walk reads happen only while decoding
    a_read_decode: assert property (@(posedge clk) disable iff (!rst_n)
        node_rd_en |-> (phase_reg == hptd_pkg::PH_DECODE))
        else $error("node read outside decode phase");

    // Node memory is written only while parsing
    a_write_parse: assert property (@(posedge clk) disable iff (!rst_n)
        (|node_wen) |-> (phase_reg == hptd_pkg::PH_PARSE))
        else $error("node write outside parse phase");

    // A pending leaf symbol byte keeps the block in the parse phase
    a_await_parse: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> (phase_reg == hptd_pkg::PH_PARSE))
        else $error("leaf symbol pending outside parse phase");

    // The stack never holds more open nodes than it has room for
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hptd_pkg::ST_PARSE) |=> (stack_level_reg <= LW'(STACK_DEPTH)))
        else $error("stack level beyond depth");

endmodule
